/* rtl/core/multi_pattern_byte_matcher_top_defines.svh */
// Assertion macros for the matcher; clk and rst_n are taken from the using module.
`ifndef MULTI_PATTERN_BYTE_MATCHER_TOP_DEFINES_SVH
`define MULTI_PATTERN_BYTE_MATCHER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MPBM_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define MPBM_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MPBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MPBM_ASSERT_ALWAYS(lbl, cond, msg)
`define MPBM_ASSERT_IMPLY(lbl, ante, cons, msg)
`define MPBM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/core/mpbm_pkg.sv */
package mpbm_pkg;

    localparam int STATE_COUNT_DEF           = 1024;
    localparam int PATTERN_COUNT_DEF         = 1024;
    localparam int REPORT_ENTRIES_DEF        = 4096;
    localparam int MAX_REPORTS_PER_STATE_DEF = 16;

    localparam int BYTE_VALUES = 256;
    localparam int MODE_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 18;
    localparam int VALUE_W     = 32;
    localparam int STATE_W     = 10;
    localparam int PAT_W       = 10;
    localparam int LEN_W       = 16;
    localparam int RSV_W       = 13;
    localparam int FRS_W       = 11;
    localparam int ADDR_SPAN   = 262144;

    localparam logic [FRS_W-1:0]   FRS_RESET  = 11'd1024;
    localparam logic [VALUE_W-1:0] OFFSET_MAX = 32'hFFFF_FFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_SCAN      = 3'd0,
        MODE_WR_NEXT   = 3'd1,
        MODE_WR_START  = 3'd2,
        MODE_WR_INDEX  = 3'd3,
        MODE_WR_LENGTH = 3'd4,
        MODE_RESTART   = 3'd5
    } mode_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_STEP  = 8'b0000_0010,
        ST_START = 8'b0000_0100,
        ST_LIST  = 8'b0000_1000,
        ST_ENTRY = 8'b0001_0000,
        ST_PAT   = 8'b0010_0000,
        ST_EMIT  = 8'b0100_0000,
        ST_FLUSH = 8'b1000_0000
    } ctl_state_t;

    typedef struct packed {
        logic accept;       // input beat taken this cycle
        logic step;         // commit next state and offset
        logic start_read;   // read list bounds
        logic list_init;    // load list walk registers
        logic idx_read;     // read report entry
        logic len_read;     // read pattern length
        logic advance;      // next list entry
        logic hold_load;    // park current candidate
        logic hold_drop;    // empty the parking register
        logic out_load;     // parked candidate to output
        logic out_last;     // ... flagged last of run
    } cmd_t;

    typedef struct packed {
        logic is_scan;
        logic reports;
        logic entry_ok;
        logic skip;
        logic hold_valid;
        logic out_free;
    } stat_t;

endpackage

/* rtl/core/mpbm_ifs.sv */
interface mpbm_scan_if;
    import mpbm_pkg::*;
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [BYTE_W-1:0]  data_byte;
    logic [ADDR_W-1:0]  table_address;
    logic [VALUE_W-1:0] load_value;
    modport source (output valid, mode, data_byte, table_address, load_value, input ready);
    modport sink (input valid, mode, data_byte, table_address, load_value, output ready);
endinterface

interface mpbm_result_if;
    import mpbm_pkg::*;
    logic               valid;
    logic               ready;
    logic [PAT_W-1:0]   pattern_index;
    logic [VALUE_W-1:0] end_offset;
    logic [LEN_W-1:0]   match_length;
    logic               last_of_run;
    modport source (output valid, pattern_index, end_offset, match_length, last_of_run,
                    input ready);
    modport sink (input valid, pattern_index, end_offset, match_length, last_of_run,
                  output ready);
endinterface

interface mpbm_cfg_if;
    import mpbm_pkg::*;
    logic             valid;
    logic             ready;
    logic [FRS_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/core/mpbm_ctrl.sv */
module mpbm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mpbm_pkg::stat_t stat,
    output mpbm_pkg::cmd_t  cmd
);
    import mpbm_pkg::*;

    ctl_state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && stat.is_scan)
                    state_next = ST_STEP;
            end
            ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                if (stat.reports)
                begin
                    cmd.start_read = 1'b1;
                    state_next     = ST_LIST;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_LIST:
            begin
                cmd.list_init = 1'b1;
                state_next    = ST_ENTRY;
            end
            ST_ENTRY:
            begin
                if (stat.entry_ok)
                begin
                    cmd.idx_read = 1'b1;
                    state_next   = ST_PAT;
                end
                else
                    state_next = ST_FLUSH;
            end
            ST_PAT:
            begin
                cmd.len_read = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                priority if (stat.skip)
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_ENTRY;
                end
                else if (!stat.hold_valid)
                begin
                    cmd.hold_load = 1'b1;
                    cmd.advance   = 1'b1;
                    state_next    = ST_ENTRY;
                end
                else if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.hold_load = 1'b1;
                    cmd.advance   = 1'b1;
                    state_next    = ST_ENTRY;
                end
            end
            ST_FLUSH:
            begin
                priority if (!stat.hold_valid)
                    state_next = ST_IDLE;
                else if (stat.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_last  = 1'b1;
                    cmd.hold_drop = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/core/mpbm_dp.sv */
`include "multi_pattern_byte_matcher_top_defines.svh"

module mpbm_dp #(
    parameter int STATE_COUNT           = mpbm_pkg::STATE_COUNT_DEF,
    parameter int PATTERN_COUNT         = mpbm_pkg::PATTERN_COUNT_DEF,
    parameter int REPORT_ENTRIES        = mpbm_pkg::REPORT_ENTRIES_DEF,
    parameter int MAX_REPORTS_PER_STATE = mpbm_pkg::MAX_REPORTS_PER_STATE_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mpbm_pkg::cmd_t               cmd,
    output mpbm_pkg::stat_t              stat,
    input  logic [mpbm_pkg::MODE_W-1:0]  in_mode,
    input  logic [mpbm_pkg::BYTE_W-1:0]  in_byte,
    input  logic [mpbm_pkg::ADDR_W-1:0]  in_addr,
    input  logic [mpbm_pkg::VALUE_W-1:0] in_value,
    input  logic                         cfg_we,
    input  logic [mpbm_pkg::FRS_W-1:0]   cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mpbm_pkg::PAT_W-1:0]   out_pat,
    output logic [mpbm_pkg::VALUE_W-1:0] out_end,
    output logic [mpbm_pkg::LEN_W-1:0]   out_len,
    output logic                         out_last
);
    import mpbm_pkg::*;

    // table depths clipped to what the address field can reach
    localparam int NS_FULL  = STATE_COUNT * BYTE_VALUES;
    localparam int NS_DEPTH = (NS_FULL < ADDR_SPAN) ? NS_FULL : ADDR_SPAN;
    localparam int RS_DEPTH = (STATE_COUNT + 1 < ADDR_SPAN) ? STATE_COUNT + 1 : ADDR_SPAN;
    localparam int RI_DEPTH = (REPORT_ENTRIES < ADDR_SPAN) ? REPORT_ENTRIES : ADDR_SPAN;
    localparam int PL_DEPTH = (PATTERN_COUNT < ADDR_SPAN) ? PATTERN_COUNT : ADDR_SPAN;
    localparam int NS_AW = (NS_DEPTH > 1) ? $clog2(NS_DEPTH) : 1;
    localparam int RS_AW = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1;
    localparam int RI_AW = (RI_DEPTH > 1) ? $clog2(RI_DEPTH) : 1;
    localparam int PL_AW = (PL_DEPTH > 1) ? $clog2(PL_DEPTH) : 1;
    localparam int TK_W  = $clog2(MAX_REPORTS_PER_STATE + 1);

    logic [STATE_W-1:0] ns_mem [NS_DEPTH];
    logic [RSV_W-1:0]   rs_mem [RS_DEPTH];
    logic [PAT_W-1:0]   ri_mem [RI_DEPTH];
    logic [LEN_W-1:0]   pl_mem [PL_DEPTH];

    logic [FRS_W-1:0]   frs_reg;
    logic [STATE_W-1:0] state_reg;
    logic [VALUE_W-1:0] offset_reg;
    logic [STATE_W-1:0] ns_rdata_reg;
    logic               slot_ok_reg;
    logic [RSV_W-1:0]   rs_first_reg, rs_last_reg;
    logic [RSV_W-1:0]   entry_reg, last_reg;
    logic [TK_W-1:0]    taken_reg;
    logic [PAT_W-1:0]   ri_rdata_reg;
    logic [PAT_W-1:0]   pat_reg;
    logic               pat_ok_reg;
    logic [LEN_W-1:0]   pl_rdata_reg;
    logic               hold_valid_reg;
    logic [PAT_W-1:0]   hold_pat_reg;
    logic [LEN_W-1:0]   hold_len_reg;
    logic               out_valid_reg;

    logic [ADDR_W-1:0]  slot_addr;
    logic [FRS_W-1:0]   slot;
    logic [LEN_W-1:0]   cand_len;
    logic               out_free;

    assign slot_addr = {state_reg, in_byte};
    assign slot      = {1'b0, state_reg} - frs_reg;
    assign cand_len  = pat_ok_reg ? pl_rdata_reg : '0;
    assign out_free  = !out_valid_reg || out_ready;

    assign stat.is_scan    = (in_mode == MODE_SCAN);
    assign stat.reports    = ({1'b0, state_reg} >= frs_reg) && (32'(slot) < STATE_COUNT);
    assign stat.entry_ok   = (entry_reg < last_reg)
                             && (taken_reg < TK_W'(MAX_REPORTS_PER_STATE))
                             && (32'(entry_reg) < REPORT_ENTRIES);
    assign stat.skip       = (32'(cand_len) > offset_reg);
    assign stat.hold_valid = hold_valid_reg;
    assign stat.out_free   = out_free;

    // table loads and reads
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_mode == MODE_WR_NEXT && 32'(in_addr) < NS_DEPTH
            && 32'(in_value[STATE_W-1:0]) < STATE_COUNT)
            ns_mem[NS_AW'(in_addr)] <= in_value[STATE_W-1:0];
        if (cmd.accept)
            ns_rdata_reg <= ns_mem[NS_AW'(slot_addr)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_mode == MODE_WR_START && 32'(in_addr) < RS_DEPTH)
            rs_mem[RS_AW'(in_addr)] <= in_value[RSV_W-1:0];
        if (cmd.start_read)
        begin
            rs_first_reg <= rs_mem[RS_AW'(slot)];
            rs_last_reg  <= rs_mem[RS_AW'(slot + 1'b1)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_mode == MODE_WR_INDEX && 32'(in_addr) < RI_DEPTH)
            ri_mem[RI_AW'(in_addr)] <= in_value[PAT_W-1:0];
        if (cmd.idx_read)
            ri_rdata_reg <= ri_mem[RI_AW'(entry_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_mode == MODE_WR_LENGTH && 32'(in_addr) < PL_DEPTH)
            pl_mem[PL_AW'(in_addr)] <= in_value[LEN_W-1:0];
        if (cmd.len_read)
            pl_rdata_reg <= pl_mem[PL_AW'(ri_rdata_reg)];
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            slot_ok_reg <= (32'(slot_addr) < NS_DEPTH);
        if (cmd.list_init)
        begin
            entry_reg <= rs_first_reg;
            last_reg  <= rs_last_reg;
        end
        else if (cmd.advance)
            entry_reg <= entry_reg + 1'b1;
        if (cmd.len_read)
        begin
            pat_reg    <= ri_rdata_reg;
            pat_ok_reg <= (32'(ri_rdata_reg) < PATTERN_COUNT);
        end
        if (cmd.hold_load)
        begin
            hold_pat_reg <= pat_reg;
            hold_len_reg <= cand_len;
        end
        if (cmd.out_load)
        begin
            out_pat  <= hold_pat_reg;
            out_end  <= offset_reg;
            out_len  <= hold_len_reg;
            out_last <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frs_reg        <= FRS_RESET;
            state_reg      <= '0;
            offset_reg     <= '0;
            taken_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                frs_reg <= cfg_data;
            if (cmd.accept && in_mode == MODE_RESTART)
            begin
                state_reg  <= '0;
                offset_reg <= in_value;
            end
            else if (cmd.step)
            begin
                state_reg <= slot_ok_reg ? ns_rdata_reg : '0;
                if (offset_reg != OFFSET_MAX)
                    offset_reg <= offset_reg + 1'b1;
            end
            if (cmd.list_init)
                taken_reg <= '0;
            else if (cmd.advance)
                taken_reg <= taken_reg + 1'b1;
            if (cmd.hold_load)
                hold_valid_reg <= 1'b1;
            else if (cmd.hold_drop)
                hold_valid_reg <= 1'b0;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    `MPBM_ASSERT_IMPLY(a_no_overwrite, cmd.out_load, out_free, "result overwritten")
    `MPBM_ASSERT_ALWAYS(a_taken_cap, taken_reg <= TK_W'(MAX_REPORTS_PER_STATE), "too many")
    `MPBM_ASSERT_NEXT(a_offset_moves, cmd.step, offset_reg != '0, "offset did not advance")
    `MPBM_ASSERT_IMPLY(a_park_full, cmd.out_load, hold_valid_reg, "empty hold sent")

endmodule

/* rtl/core/multi_pattern_byte_matcher_top.sv */
// Dense-table Aho-Corasick scanner.
// Channels: scan (valid/ready) carries one item per beat: a mode, a byte, a
// table address and a 32-bit value. Modes 1-4 load the next-state, report
// start, report index and pattern length tables; mode 5 restarts at the root
// with a new stream offset; mode 0 scans one byte. result (valid/ready) carries
// one match per beat, last_of_run set on the final match of a byte. cfg
// (valid/ready, always ready) writes first_reporting_state.
// Sequencing: a load or restart beat is taken in idle. A scan byte commits its
// next state; if that state reports, the sequencer reads the list bounds, then
// each entry's report index and pattern length, one registered memory read at a
// time; each match is parked and leaves as the next is parked or at the flush.
// Reset: state and offset clear, first_reporting_state becomes 1024; table
// contents are not cleared and must be loaded before use. No clearing pass.
// Stall: one result register plus one parked match; while both are full the
// walk waits, and scan stays not ready until the byte's run is done. A result
// left waiting does not block the next input beat.
module multi_pattern_byte_matcher_top #(
    parameter int STATE_COUNT           = mpbm_pkg::STATE_COUNT_DEF,
    parameter int PATTERN_COUNT         = mpbm_pkg::PATTERN_COUNT_DEF,
    parameter int REPORT_ENTRIES        = mpbm_pkg::REPORT_ENTRIES_DEF,
    parameter int MAX_REPORTS_PER_STATE = mpbm_pkg::MAX_REPORTS_PER_STATE_DEF
) (
    input logic           clk,
    input logic           rst_n,
    mpbm_scan_if.sink     scan,
    mpbm_result_if.source result,
    mpbm_cfg_if.sink      cfg
);
    import mpbm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // config register has no back-pressure
    assign cfg.ready = 1'b1;

    mpbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (scan.valid),
        .in_ready (scan.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mpbm_dp #(
        .STATE_COUNT           (STATE_COUNT),
        .PATTERN_COUNT         (PATTERN_COUNT),
        .REPORT_ENTRIES        (REPORT_ENTRIES),
        .MAX_REPORTS_PER_STATE (MAX_REPORTS_PER_STATE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_mode   (scan.mode),
        .in_byte   (scan.data_byte),
        .in_addr   (scan.table_address),
        .in_value  (scan.load_value),
        .cfg_we    (cfg.valid),
        .cfg_data  (cfg.data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_pat   (result.pattern_index),
        .out_end   (result.end_offset),
        .out_len   (result.match_length),
        .out_last  (result.last_of_run)
    );

endmodule

/* test/multi_pattern_byte_matcher_top_tb.sv */
`timescale 1ns / 100ps

module multi_pattern_byte_matcher_top_tb;
    import mpbm_pkg::*;

    // mode codes the block must ignore
    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
    localparam int STARTS = 1025;
    localparam int ENTRIES = 4096;
    localparam int PATTERNS = 1024;
    localparam int MAX_REPORTS = 16;
    localparam int DRAIN_CYCLES = 120;
    localparam int LIVE_COUNT = 3;
    localparam int HEAD_ENTRIES = 19;
    localparam int RAND_PER_PHASE = 7;

    localparam logic [STATE_W-1:0] LIVE_STATES [LIVE_COUNT] = '{10'd0, 10'd1, 10'd1023};
    localparam logic [BYTE_W-1:0]  ALPHABET [4] = '{8'h00, 8'h55, 8'hAA, 8'hFF};
    localparam logic [PAT_W-1:0]   PAT_SET [5] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1023};
    localparam int unsigned        START_SET [7] = '{0, 1, 2, 3, 1022, 1023, 1024};
    localparam logic [FRS_W-1:0]   FRS_PLAN [5] = '{11'd0, 11'd2047, 11'd1021, 11'd1024, 11'd1};

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [BYTE_W-1:0]  data_byte;
        logic [ADDR_W-1:0]  table_address;
        logic [VALUE_W-1:0] load_value;
    } scan_item_t;

    typedef struct {
        logic [PAT_W-1:0]   pattern_index;
        logic [VALUE_W-1:0] end_offset;
        logic [LEN_W-1:0]   match_length;
        logic               last_of_run;
    } match_t;

    logic clk;
    logic rst_n;

    mpbm_scan_if   scan ();
    mpbm_result_if result ();
    mpbm_cfg_if    cfg ();

    multi_pattern_byte_matcher_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    // Scanner mirror. Scan bytes come from a four-byte alphabet and rows only
    // point at live states, so just the live rows at those bytes, the list
    // bounds of reachable slots, the list heads, the last two entries and a
    // few patterns are ever read; all of them are loaded before scanning.
    logic [STATE_W-1:0] next_tbl [ADDR_SPAN];
    logic [RSV_W-1:0]   start_tbl [STARTS];
    logic [PAT_W-1:0]   index_tbl [ENTRIES];
    logic [LEN_W-1:0]   length_tbl [PATTERNS];
    logic [STATE_W-1:0] mirror_state = '0;
    logic [VALUE_W-1:0] offset = '0;
    logic [FRS_W-1:0]   frs = FRS_RESET;

    scan_item_t pending_beats [$];
    match_t     pending_matches [$];
    int  errors = 0;
    int  tx_idle;
    int  rx_idle;
    logic scan_took;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [STATE_W-1:0] pick_live();
        return LIVE_STATES[$urandom_range(LIVE_COUNT - 1)];
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        return ALPHABET[$urandom_range(3)];
    endfunction

    function automatic logic [PAT_W-1:0] pick_pat();
        return PAT_SET[$urandom_range(4)];
    endfunction

    task automatic queue_beat(input scan_item_t it);
        pending_beats.insert(pending_beats.size(), it);
    endtask

    // Walk one accepted beat through the mirror and queue the matches it makes.
    task automatic step_scanner(input scan_item_t it);
        int slot;
        int first;
        int last;
        int taken;
        int pat;
        int len;
        int made;
        match_t m;
        made = 0;
        case (it.mode)
            MODE_SCAN:
            begin
                mirror_state = next_tbl[{mirror_state, it.data_byte}];
                if (offset != OFFSET_MAX)
                    offset = offset + 1'b1;
                if (int'(mirror_state) >= int'(frs))
                begin
                    slot = int'(mirror_state) - int'(frs);
                    if (slot + 1 <= STARTS - 1)
                    begin
                        first = int'(start_tbl[slot]);
                        last = int'(start_tbl[slot + 1]);
                        taken = 0;
                        for (int e = first; e < last && taken < MAX_REPORTS; e++)
                        begin
                            if (e >= ENTRIES)
                                break;
                            taken++;
                            pat = int'(index_tbl[e]);
                            len = int'(length_tbl[pat]);
                            // pattern would start before offset zero
                            if (longint'(len) > longint'(offset))
                                continue;
                            m.pattern_index = PAT_W'(pat);
                            m.end_offset = offset;
                            m.match_length = LEN_W'(len);
                            m.last_of_run = 1'b0;
                            pending_matches.insert(pending_matches.size(), m);
                            made++;
                        end
                        if (made > 0)
                            pending_matches[$].last_of_run = 1'b1;
                    end
                end
            end
            MODE_WR_NEXT:
                next_tbl[it.table_address] = it.load_value[STATE_W-1:0];
            MODE_WR_START:
                if (it.table_address < STARTS)
                    start_tbl[it.table_address] = it.load_value[RSV_W-1:0];
            MODE_WR_INDEX:
                if (it.table_address < ENTRIES)
                    index_tbl[it.table_address] = it.load_value[PAT_W-1:0];
            MODE_WR_LENGTH:
                if (it.table_address < PATTERNS)
                    length_tbl[it.table_address] = it.load_value[LEN_W-1:0];
            MODE_RESTART:
            begin
                mirror_state = '0;
                offset = it.load_value;
            end
            default:
                ;
        endcase
    endtask

    function automatic scan_item_t make_beat(input logic [MODE_W-1:0] mode,
                                             input int unsigned addr,
                                             input logic [VALUE_W-1:0] value,
                                             input logic [BYTE_W-1:0] data_byte);
        scan_item_t it;
        it.mode = mode;
        it.data_byte = data_byte;
        it.table_address = ADDR_W'(addr);
        it.load_value = value;
        return it;
    endfunction

    function automatic logic [LEN_W-1:0] rand_length();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return LEN_W'($urandom_range(12));
        else if (r < 90)
            return 16'hFFFF;
        return LEN_W'($urandom);
    endfunction

    // List starts stay near the table head or run off its end.
    function automatic logic [RSV_W-1:0] rand_start();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return RSV_W'($urandom_range(3));
        else if (r < 75)
            return '0;                                      // empty or reversed list
        else if (r < 90)
            return RSV_W'(4094 + $urandom_range(6));        // runs off the entry table
        return RSV_W'($urandom_range(8191, 4096));
    endfunction

    function automatic scan_item_t rand_beat();
        int r;
        scan_item_t it;
        it = make_beat(MODE_SCAN, $urandom_range(ADDR_SPAN - 1), $urandom, pick_byte());
        r = $urandom_range(99);
        if (r < 60)
            ;
        else if (r < 68)
        begin
            it.mode = MODE_RESTART;
            case ($urandom_range(3))
                0, 1: it.load_value = $urandom_range(50);
                2:    it.load_value = $urandom;
                default: it.load_value = OFFSET_MAX - $urandom_range(3);
            endcase
        end
        else if (r < 76)
        begin
            it.mode = MODE_WR_NEXT;
            if ($urandom_range(1))
                it.table_address = {pick_live(), pick_byte()};
            // rows only ever point at live states; upper bits are masked
            it.load_value = {22'($urandom_range((1 << 22) - 1)), pick_live()};
        end
        else if (r < 83)
        begin
            it.mode = MODE_WR_START;
            it.table_address = ADDR_W'($urandom_range(1100));
            it.load_value = {19'($urandom), rand_start()};
        end
        else if (r < 90)
        begin
            it.mode = MODE_WR_INDEX;
            it.table_address = ADDR_W'($urandom_range(4200));
            it.load_value = {22'($urandom_range((1 << 22) - 1)), pick_pat()};
        end
        else if (r < 97)
        begin
            it.mode = MODE_WR_LENGTH;
            it.table_address = ADDR_W'($urandom_range(1100));
            it.load_value = {16'($urandom_range(65535)), rand_length()};
        end
        else
            it.mode = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
        return it;
    endfunction

    task automatic load_tables();
        for (int s = 0; s < LIVE_COUNT; s++)
            for (int b = 0; b < 4; b++)
                queue_beat(make_beat(MODE_WR_NEXT, 32'({LIVE_STATES[s], ALPHABET[b]}),
                                     32'(pick_live()), ALPHABET[b]));
        for (int k = 0; k < 7; k++)
            queue_beat(make_beat(MODE_WR_START, START_SET[k], 32'(rand_start()), 8'h00));
        for (int unsigned k = 0; k < HEAD_ENTRIES; k++)
            queue_beat(make_beat(MODE_WR_INDEX, k, 32'(pick_pat()), 8'h00));
        for (int unsigned k = ENTRIES - 2; k < ENTRIES; k++)
            queue_beat(make_beat(MODE_WR_INDEX, k, 32'(pick_pat()), 8'h00));
        for (int k = 0; k < 5; k++)
            queue_beat(make_beat(MODE_WR_LENGTH, 32'(PAT_SET[k]), 32'(rand_length()), 8'h00));
    endtask

    // Field extremes, every mode, ignored writes, saturation, early matches.
    task automatic queue_directed();
        queue_beat(make_beat(MODE_RESTART, 0, 32'd0, 8'h00));
        queue_beat(make_beat(MODE_SCAN, 0, 32'd0, 8'h00));
        queue_beat(make_beat(MODE_SCAN, ADDR_SPAN - 1, OFFSET_MAX, 8'hFF));
        queue_beat(make_beat(MODE_SCAN, 0, 32'd0, 8'hAA));
        queue_beat(make_beat(MODE_SCAN, 0, 32'd0, 8'h55));
        queue_beat(make_beat(MODE_WR_NEXT, ADDR_SPAN - 1, OFFSET_MAX, 8'h00));
        queue_beat(make_beat(MODE_WR_START, 1025, 32'd5, 8'h00));
        queue_beat(make_beat(MODE_WR_START, ADDR_SPAN - 1, 32'd5, 8'h00));
        queue_beat(make_beat(MODE_WR_START, 1024, OFFSET_MAX, 8'h00));
        queue_beat(make_beat(MODE_WR_INDEX, 4096, 32'd3, 8'h00));
        queue_beat(make_beat(MODE_WR_INDEX, 4095, OFFSET_MAX, 8'h00));
        queue_beat(make_beat(MODE_WR_LENGTH, 1024, 32'd1, 8'h00));
        queue_beat(make_beat(MODE_WR_LENGTH, 1023, 32'h0001_0003, 8'h00));
        queue_beat(make_beat(MODE_SPARE_A, 0, 32'd0, 8'h00));
        queue_beat(make_beat(MODE_SPARE_B, ADDR_SPAN - 1, OFFSET_MAX, 8'hFF));
        queue_beat(make_beat(MODE_RESTART, 0, OFFSET_MAX - 1, 8'h00));
        for (int i = 0; i < 3; i++)
            queue_beat(make_beat(MODE_SCAN, 0, 32'd0, pick_byte()));
        queue_beat(make_beat(MODE_RESTART, 0, 32'd3, 8'h00));
        for (int i = 0; i < 4; i++)
            queue_beat(make_beat(MODE_SCAN, 0, 32'd0, pick_byte()));
    endtask

    task automatic write_frs(input logic [FRS_W-1:0] value);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        frs = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_beats.size() > 0 || scan.valid || pending_matches.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Beat driver: holds a beat until it is taken, then offers the next one or idles; sets result ready at random.
    always @(negedge clk)
    begin
        scan_item_t it;
        if (!rst_n)
        begin
            scan.valid <= 1'b0;
            scan.mode <= MODE_SCAN;
            scan.data_byte <= '0;
            scan.table_address <= '0;
            scan.load_value <= '0;
            result.ready <= 1'b0;
        end
        else
        begin
            if (!scan.valid || scan_took)
            begin
                if (pending_beats.size() > 0 && $urandom_range(99) >= tx_idle)
                begin
                    it = pending_beats.pop_front();
                    scan.mode <= it.mode;
                    scan.data_byte <= it.data_byte;
                    scan.table_address <= it.table_address;
                    scan.load_value <= it.load_value;
                    scan.valid <= 1'b1;
                end
                else
                    scan.valid <= 1'b0;
            end
            result.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    // Monitor: feeds taken beats to the mirror and checks every match beat.
    always @(posedge clk)
    begin
        scan_item_t it;
        match_t m;
        scan_took <= scan.valid && scan.ready;
        if (rst_n && scan.valid && scan.ready)
        begin
            it.mode = scan.mode;
            it.data_byte = scan.data_byte;
            it.table_address = scan.table_address;
            it.load_value = scan.load_value;
            step_scanner(it);
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_matches.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected match exp none act pat=%0d end=%0h len=%0d last=%0b",
                         $time, result.pattern_index, result.end_offset,
                         result.match_length, result.last_of_run);
            end
            else
            begin
                m = pending_matches.pop_front();
                if (result.pattern_index !== m.pattern_index
                    || result.end_offset !== m.end_offset
                    || result.match_length !== m.match_length
                    || result.last_of_run !== m.last_of_run)
                begin
                    errors++;
                    $display("%0t: match mismatch exp pat=%0d end=%0h len=%0d last=%0b",
                             $time, m.pattern_index, m.end_offset, m.match_length,
                             m.last_of_run);
                    $display("%0t:                act pat=%0d end=%0h len=%0d last=%0b",
                             $time, result.pattern_index, result.end_offset,
                             result.match_length, result.last_of_run);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("multi_pattern_byte_matcher_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        tx_idle = 35;
        rx_idle = 65;
        cfg.valid = 1'b0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // tables first, under the reset threshold no state reports
        load_tables();
        drain();

        for (int p = 0; p < 5; p++)
        begin
            // sender 35 / receiver 65, then swapped, then no idling
            if (p < 2)
            begin
                tx_idle = 35;
                rx_idle = 65;
            end
            else if (p < 4)
            begin
                tx_idle = 65;
                rx_idle = 35;
            end
            else
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            write_frs(FRS_PLAN[p]);
            if (p == 0)
                queue_directed();
            for (int i = 0; i < RAND_PER_PHASE; i++)
                queue_beat(rand_beat());
            drain();
        end

        if (errors == 0)
            $display("multi_pattern_byte_matcher_top_tb OK");
        else
            $display("multi_pattern_byte_matcher_top_tb NOT OK");
        $finish;
    end

endmodule
